// ===== hw/rtl/tsavp_pkg.sv =====
// Package for the transport stream audio/video PID scanner.
// Holds the field widths, stream constants and the audio table request type.
// No dependencies.
`timescale 1ns / 1ps

package tsavp_pkg;

    // Field widths fixed by the stream format.
    localparam int BYTE_W  = 8;
    localparam int PID_W   = 13;
    localparam int SID_W   = 9;
    localparam int CNT_W   = 20;
    localparam int ACNT_W  = 5;

    // Transport stream header constants.
    localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'h47;
    localparam logic [BYTE_W-1:0] PID_HI_MASK   = 8'h1F;
    localparam logic [BYTE_W-1:0] PUSI_MASK     = 8'h40;
    localparam logic [BYTE_W-1:0] ADAPT_MASK    = 8'h20;

    // PES stream id ranges.
    localparam logic [BYTE_W-1:0] SID_PRIV1     = 8'hBD;
    localparam logic [BYTE_W-1:0] SID_VIDEO_LO  = 8'hE0;
    localparam logic [BYTE_W-1:0] SID_VIDEO_HI  = 8'hEF;
    localparam logic [BYTE_W-1:0] SID_AUDIO_LO  = 8'hC0;
    localparam logic [BYTE_W-1:0] SID_AUDIO_HI  = 8'hDF;

    // Stream id offsets within the packet.
    localparam logic [SID_W-1:0] SID_POS_PLAIN = 9'd7;
    localparam logic [SID_W-1:0] SID_POS_ADAPT = 9'd8;

    // Packet counter limits and the probe register reset value.
    localparam logic [CNT_W-1:0] COUNT_MAX   = 20'hFFFFF;
    localparam logic [CNT_W-1:0] PROBE_RESET = 20'd10000;

    // Request presented to every audio table cell.
    typedef struct packed {
        logic             wr;
        logic [PID_W-1:0] pid;
    } t_tbl_req;

endpackage

// ===== hw/rtl/ts_av_pid_scanner_top.sv =====
// Transport stream scanner: bytes in, one result per byte out.
// One byte per cycle is taken while the output register is not stalled.
// Each result is registered; the audio table lookup runs along the cell row.
// Reset (synchronous, active low) clears control, sets hunting, presets the probe.
// Depends on tsavp_pkg and tsavp_chain.
`timescale 1ns / 1ps

module ts_av_pid_scanner_top #(
    parameter int AUDIO_ENTRIES = 16,
    parameter int PACKET_BYTES  = 188
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_in_sync,
    output logic        o_video_found,
    output logic [12:0] o_video_pid,
    output logic [4:0]  o_audio_count,
    output logic        o_new_audio,
    output logic [12:0] o_new_audio_pid,
    output logic        o_new_audio_ac3,
    output logic        o_table_full_drop,
    output logic        o_scan_done
);

    localparam int PW = $clog2(PACKET_BYTES);
    localparam int CW = $clog2(AUDIO_ENTRIES + 1);
    localparam int PID_W = tsavp_pkg::PID_W;
    localparam int SID_W = tsavp_pkg::SID_W;
    localparam int CNT_W = tsavp_pkg::CNT_W;

    // Parser and scan state.
    logic [CNT_W-1:0] r_probe;
    logic [PW-1:0]    r_pos,   n_pos;
    logic             r_hunt,  n_hunt;
    logic             r_pusi,  n_pusi;
    logic             r_adapt, n_adapt;
    logic [PID_W-1:0] r_pid,   n_pid;
    logic [SID_W-1:0] r_sid,   n_sid;
    logic [CNT_W-1:0] r_pcnt,  n_pcnt;
    logic             r_fin,   n_fin;
    logic             r_vid,   n_vid;
    logic [PID_W-1:0] r_vpid,  n_vpid;
    logic [CW-1:0]    r_acnt,  n_acnt;

    // Output register.
    logic             r_out_valid;
    logic             r_sync,  n_sync;
    logic             r_fresh, n_fresh;
    logic [PID_W-1:0] r_fpid,  n_fpid;
    logic             r_fac3,  n_fac3;
    logic             r_drop,  n_drop;
    logic             r_ovid;
    logic [PID_W-1:0] r_ovpid;
    logic [CW-1:0]    r_oacnt;
    logic             r_odone;

    logic                in_xfer;
    logic                seen;
    logic                is_video;
    logic                is_audio;
    tsavp_pkg::t_tbl_req tbl_req;

    // A new byte is taken whenever the output register is free or being emptied.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Stream id classification of the current byte.
    assign is_video = (i_data_byte >= tsavp_pkg::SID_VIDEO_LO) &&
                      (i_data_byte <= tsavp_pkg::SID_VIDEO_HI);
    assign is_audio = ((i_data_byte >= tsavp_pkg::SID_AUDIO_LO) &&
                       (i_data_byte <= tsavp_pkg::SID_AUDIO_HI)) ||
                      (i_data_byte == tsavp_pkg::SID_PRIV1);

    // Audio table: the row of cells looks up the packet PID.
    tsavp_chain #(
        .AUDIO_ENTRIES (AUDIO_ENTRIES),
        .CW            (CW)
    ) u_chain (
        .i_clk   (i_clk),
        .i_req   (tbl_req),
        .i_count (r_acnt),
        .o_seen  (seen)
    );

    // Next state and result for the byte on the input.
    always_comb begin
        n_pos   = r_pos;
        n_hunt  = r_hunt;
        n_pusi  = r_pusi;
        n_adapt = r_adapt;
        n_pid   = r_pid;
        n_sid   = r_sid;
        n_pcnt  = r_pcnt;
        n_fin   = r_fin;
        n_vid   = r_vid;
        n_vpid  = r_vpid;
        n_acnt  = r_acnt;
        n_sync  = 1'b0;
        n_fresh = 1'b0;
        n_fpid  = '0;
        n_fac3  = 1'b0;
        n_drop  = 1'b0;
        tbl_req.wr  = 1'b0;
        tbl_req.pid = r_pid;

        if (r_fin) begin
            // Scan finished: the byte is ignored.
        end else if (r_hunt || (r_pos == '0)) begin
            if (i_data_byte == tsavp_pkg::SYNC_BYTE) begin
                n_hunt  = 1'b0;
                n_pos   = PW'(1);
                n_pcnt  = (r_pcnt != tsavp_pkg::COUNT_MAX) ? r_pcnt + 1'b1 : r_pcnt;
                n_pusi  = 1'b0;
                n_adapt = 1'b0;
                n_pid   = '0;
                n_sid   = '0;
                n_sync  = 1'b1;
            end else begin
                n_hunt = 1'b1;
                n_pos  = '0;
            end
        end else begin
            n_sync = 1'b1;

            // Header fields.
            if (r_pos == PW'(1)) begin
                n_pusi = (i_data_byte & tsavp_pkg::PUSI_MASK) != '0;
                n_pid  = {5'(i_data_byte & tsavp_pkg::PID_HI_MASK), 8'h00};
            end else if (r_pos == PW'(2)) begin
                n_pid = {r_pid[PID_W-1:8], i_data_byte};
            end else if (r_pos == PW'(3)) begin
                n_adapt = (i_data_byte & tsavp_pkg::ADAPT_MASK) != '0;
                n_sid   = n_adapt ? '0 : tsavp_pkg::SID_POS_PLAIN;
            end else if (r_pos == PW'(4)) begin
                if (r_adapt) begin
                    n_sid = tsavp_pkg::SID_POS_ADAPT + SID_W'(i_data_byte);
                end
            end

            // Stream id byte.
            if (r_pusi && (r_pos >= PW'(5)) && (SID_W'(r_pos) == r_sid)) begin
                if (is_video) begin
                    n_vid  = 1'b1;
                    n_vpid = r_pid;
                end else if (is_audio && !seen) begin
                    if (r_acnt != CW'(AUDIO_ENTRIES)) begin
                        tbl_req.wr = 1'b1;
                        n_acnt  = r_acnt + 1'b1;
                        n_fresh = 1'b1;
                        n_fpid  = r_pid;
                        n_fac3  = (i_data_byte == tsavp_pkg::SID_PRIV1);
                    end else begin
                        n_drop = 1'b1;
                    end
                end
            end

            // End of packet and stop check.
            if (r_pos == PW'(PACKET_BYTES - 1)) begin
                n_pos = '0;
                if (n_vid && (n_acnt != '0) && (r_pcnt >= r_probe)) begin
                    n_fin = 1'b1;
                end
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end

        // The table is written only on an input transfer.
        tbl_req.wr = tbl_req.wr && in_xfer;
    end

    // Probe register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= tsavp_pkg::PROBE_RESET;
        end else if (i_cfg_we) begin
            r_probe <= i_cfg_data;
        end
    end

    // Parser state, updated on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hunt  <= 1'b1;
            r_pusi  <= 1'b0;
            r_adapt <= 1'b0;
            r_pid   <= '0;
            r_sid   <= '0;
            r_pcnt  <= '0;
            r_fin   <= 1'b0;
            r_vid   <= 1'b0;
            r_vpid  <= '0;
            r_acnt  <= '0;
        end else if (in_xfer) begin
            r_pos   <= n_pos;
            r_hunt  <= n_hunt;
            r_pusi  <= n_pusi;
            r_adapt <= n_adapt;
            r_pid   <= n_pid;
            r_sid   <= n_sid;
            r_pcnt  <= n_pcnt;
            r_fin   <= n_fin;
            r_vid   <= n_vid;
            r_vpid  <= n_vpid;
            r_acnt  <= n_acnt;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload, loaded with the result of each input transfer.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sync  <= n_sync;
            r_ovid  <= n_vid;
            r_ovpid <= n_vpid;
            r_oacnt <= n_acnt;
            r_fresh <= n_fresh;
            r_fpid  <= n_fpid;
            r_fac3  <= n_fac3;
            r_drop  <= n_drop;
            r_odone <= n_fin;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_in_sync         = r_sync;
    assign o_video_found     = r_ovid;
    assign o_video_pid       = r_ovpid;
    assign o_audio_count     = tsavp_pkg::ACNT_W'(r_oacnt);
    assign o_new_audio       = r_fresh;
    assign o_new_audio_pid   = r_fpid;
    assign o_new_audio_ac3   = r_fac3;
    assign o_table_full_drop = r_drop;
    assign o_scan_done       = r_odone;

endmodule

// ===== hw/rtl/tsavp_cell.sv =====
// One entry of the audio PID table, a cell in the lookup chain.
// Depends on tsavp_pkg for the request type and PID width.
`timescale 1ns / 1ps

module tsavp_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic              i_clk,
    input  tsavp_pkg::t_tbl_req i_req,
    input  logic [CW-1:0]     i_count,
    input  logic              i_hit,
    output logic              o_hit
);

    logic [tsavp_pkg::PID_W-1:0] r_pid;
    logic                        active;

    // The entry takes the PID when it is the next free slot.
    always_ff @(posedge i_clk) begin
        if (i_req.wr && (i_count == CW'(IDX))) begin
            r_pid <= i_req.pid;
        end
    end

    // Only entries below the fill count take part; the hit is passed on down the row.
    assign active = (i_count > CW'(IDX));
    assign o_hit  = i_hit | (active && (r_pid == i_req.pid));

endmodule

// ===== hw/rtl/tsavp_chain.sv =====
// Row of audio table cells with the hit signal handed from cell to cell.
// Depends on tsavp_pkg and tsavp_cell.
`timescale 1ns / 1ps

module tsavp_chain #(
    parameter int AUDIO_ENTRIES = 16,
    parameter int CW            = $clog2(AUDIO_ENTRIES + 1)
) (
    input  logic              i_clk,
    input  tsavp_pkg::t_tbl_req i_req,
    input  logic [CW-1:0]     i_count,
    output logic              o_seen
);

    logic [AUDIO_ENTRIES:0] hit;

    assign hit[0] = 1'b0;

    // One cell per table entry.
    for (genvar g = 0; g < AUDIO_ENTRIES; g++) begin : g_cell
        tsavp_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_req   (i_req),
            .i_count (i_count),
            .i_hit   (hit[g]),
            .o_hit   (hit[g+1])
        );
    end

    assign o_seen = hit[AUDIO_ENTRIES];

endmodule

// ===== hw/rtl/tsavp_checker.sv =====
// Port-level checker for the transport stream scanner, with its bind statement.
// Depends on ts_av_pid_scanner_top for the bind target only.
`timescale 1ns / 1ps

module tsavp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_stall,
    input logic        o_out_valid,
    input logic        o_in_sync,
    input logic [12:0] o_video_pid,
    input logic [4:0]  o_audio_count,
    input logic        o_new_audio,
    input logic [12:0] o_new_audio_pid,
    input logic        o_new_audio_ac3,
    input logic        o_table_full_drop,
    input logic        o_scan_done
);

    logic r_done_seen;
    logic out_xfer;

    assign out_xfer = o_out_valid && !i_out_stall;

    // Remember that a finished result has been delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done_seen <= 1'b0;
        end else if (out_xfer && o_scan_done) begin
            r_done_seen <= 1'b1;
        end
    end

    // Once the scan is done, every later result stays done and out of sync.
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_done_seen) |-> (o_scan_done && !o_in_sync))
        else $error("scan_done dropped after the scan finished");

    // A byte never both stores and drops an audio entry.
    a_store_or_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_new_audio && o_table_full_drop))
        else $error("new_audio and table_full_drop together");

    // New entry fields are clear when no entry was stored, and a store leaves a count.
    a_fresh_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_new_audio) |-> ((o_new_audio_pid == '0) && !o_new_audio_ac3))
        else $error("new audio fields set without a new entry");

    a_fresh_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_new_audio) |-> (o_audio_count != '0))
        else $error("new audio entry with zero audio count");

    // A stalled result stays valid and keeps its video PID.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_video_pid)))
        else $error("stalled result changed");

endmodule

bind ts_av_pid_scanner_top tsavp_checker u_tsavp_checker (.*);
